// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files of the decimal text parser
// depends on nothing; the including module provides clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SDTI_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked at every rising edge outside reset
`define SDTI_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/sdti_pkg.sv =====
// shared types, constants and helpers for the decimal text parser
// depends on nothing; used by sdti_digit_core and strict_decimal_text_to_int
package sdti_pkg;

   // width of the signed result value
   localparam int RESULT_BITS = 32;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam logic [7:0] CH_NUL = 8'h00;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_string;
   } req_item_type;

   typedef struct packed {
      logic                          status;
      logic signed [RESULT_BITS-1:0] value;
   } rsp_item_type;

   // an item closes the string on the marker or on a zero byte
   function automatic logic item_ends(input req_item_type item);
      return item.end_of_string || (item.character == CH_NUL);
   endfunction

endpackage

// ===== hdl/sdti_digit_core.sv =====
// parse state and digit accumulator for the decimal text parser
// depends on sdti_pkg and assert_macros.svh
`include "assert_macros.svh"

module sdti_digit_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sdti_pkg::req_item_type item,
   output sdti_pkg::rsp_item_type result
);
   import sdti_pkg::*;

   localparam int MAG_BITS = RESULT_BITS;
   localparam int ACC_BITS = RESULT_BITS + 4;

   localparam logic [MAG_BITS-1:0] MAG_ZERO  = '0;
   localparam logic [MAG_BITS-1:0] LIMIT_POS = {1'b0, {(MAG_BITS-1){1'b1}}};
   localparam logic [MAG_BITS-1:0] LIMIT_NEG = {1'b1, {(MAG_BITS-1){1'b0}}};

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS,
      PH_ERROR
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                negative_ff, negative_in;
   logic [MAG_BITS-1:0] magnitude_ff, magnitude_in;
   logic                overflowed_ff, overflowed_in;

   logic                is_blank;
   logic                is_sign;
   logic                is_digit;
   logic [3:0]          digit;
   logic [ACC_BITS-1:0] acc;
   logic [MAG_BITS-1:0] limit;
   logic                add_over;
   logic [MAG_BITS-1:0] signed_mag;
   logic                closing;
   logic                state_clear;

   // character classes
   assign is_blank = (item.character == CH_TAB) || (item.character == CH_LF) ||
                     (item.character == CH_VT)  || (item.character == CH_FF) ||
                     (item.character == CH_CR)  || (item.character == CH_SPACE);
   assign is_sign  = (item.character == CH_PLUS) || (item.character == CH_MINUS);
   assign is_digit = (item.character >= CH_ZERO) && (item.character <= CH_NINE);
   assign digit    = item.character[3:0];

   // magnitude times ten plus digit, by shift and add
   assign acc = ({4'b0000, magnitude_ff} << 3) + ({4'b0000, magnitude_ff} << 1) +
                ACC_BITS'(digit);

   // a minus sign allows one more on the magnitude
   assign limit    = negative_ff ? LIMIT_NEG : LIMIT_POS;
   assign add_over = acc > ACC_BITS'(limit);

   // next state
   always_comb begin
      phase_in      = phase_ff;
      negative_in   = negative_ff;
      magnitude_in  = magnitude_ff;
      overflowed_in = overflowed_ff;
      if (step) begin
         if (item_ends(item)) begin
            phase_in      = PH_SPACE;
            negative_in   = 1'b0;
            magnitude_in  = MAG_ZERO;
            overflowed_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_SPACE: begin
                  priority if (is_blank) begin
                     phase_in = PH_SPACE;
                  end else if (is_sign) begin
                     negative_in = (item.character == CH_MINUS);
                     phase_in    = PH_SIGN;
                  end else if (is_digit) begin
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_SIGN, PH_DIGITS: begin
                  phase_in = is_digit ? PH_DIGITS : PH_ERROR;
               end
               PH_ERROR: begin
                  phase_in = PH_ERROR;
               end
               default: begin
                  phase_in = PH_ERROR;
               end
            endcase
            // digit taken in any phase that still accepts digits
            if (is_digit && (phase_ff != PH_ERROR) && !overflowed_ff) begin
               if (add_over) begin
                  overflowed_in = 1'b1;
               end else begin
                  magnitude_in = acc[MAG_BITS-1:0];
               end
            end
         end
      end
   end

   // result for an item that closes the string
   assign signed_mag = negative_ff ? (MAG_ZERO - magnitude_ff) : magnitude_ff;

   always_comb begin
      if ((phase_ff == PH_DIGITS) && !overflowed_ff) begin
         result.status = STATUS_OK;
         result.value  = $signed(signed_mag);
      end else begin
         result.status = STATUS_ERROR;
         result.value  = '0;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SPACE;
         negative_ff   <= 1'b0;
         magnitude_ff  <= MAG_ZERO;
         overflowed_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         negative_ff   <= negative_in;
         magnitude_ff  <= magnitude_in;
         overflowed_ff <= overflowed_in;
      end
   end

   // terms for the checks below
   assign closing     = step && item_ends(item);
   assign state_clear = (phase_ff == PH_SPACE) && !negative_ff &&
                        (magnitude_ff == MAG_ZERO) && !overflowed_ff;

   // state is back at its start after every closing item
   `SDTI_ASSERT_NXT(a_clear_after_end, closing, state_clear)
   // the magnitude never passes the negative limit
   `SDTI_ASSERT_IMP(a_magnitude_bound, 1'b1, magnitude_ff <= LIMIT_NEG)
   // a minus sign is only held once the leading blanks are over
   `SDTI_ASSERT_IMP(a_sign_phase, negative_ff, phase_ff != PH_SPACE)

endmodule

// ===== hdl/strict_decimal_text_to_int.sv =====
// Strict decimal text to signed integer.
// The req_ channel carries one character per item; an item with
// end_of_string set, or with a zero character, closes the string. The
// accepted form is leading whitespace, one optional sign, one or more
// decimal digits and nothing else. Each closed string gives exactly one
// item on the rsp_ channel: status ok with the signed 32-bit value, or
// status error with value zero for a bad format or a value out of range.
// Other characters give no result.
// An accepted item is held in the input register, from where it steps the parse
// state; a closing item's result is then loaded into the result register,
// from which it is offered on the rsp_ channel.
// Throughput is one item per cycle while req_stall is low, as the
// multiply-by-ten accumulator is combinational. While rsp_stall holds,
// character items keep flowing; only a closing item waits in the input
// register, and req_stall rises then until the pending result has been taken.
// Synchronous reset clears the valid flags of both registers and the parse
// state; the block accepts items as soon as reset falls.
// depends on sdti_pkg, sdti_digit_core and assert_macros.svh
`include "assert_macros.svh"

module strict_decimal_text_to_int (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sdti_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sdti_pkg::rsp_item_type rsp_item
);
   import sdti_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic         in_ends;
   logic         out_free;
   logic         in_fire;
   logic         req_take;
   rsp_item_type core_result;
   logic         rsp_error;
   logic         rsp_keep;

   // handshake decisions
   assign in_ends   = item_ends(in_item_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_fire   = in_valid_ff && (!in_ends || out_free);
   assign req_stall = in_valid_ff && !in_fire;
   assign req_take  = req_valid && !req_stall;

   // parse state and accumulator
   sdti_digit_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (in_fire),
      .item   (in_item_ff),
      .result (core_result)
   );

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (in_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (in_fire && in_ends) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // terms for the checks below
   assign rsp_error = rsp_valid_ff && (rsp_item_ff.status == STATUS_ERROR);
   assign rsp_keep  = (in_fire && in_ends) || (rsp_valid_ff && rsp_stall);

   // an error result always carries a zero value
   `SDTI_ASSERT_IMP(a_error_zero, rsp_error, rsp_item_ff.value == '0)
   // a character that does not close the string is never held back
   `SDTI_ASSERT_IMP(a_char_flows, in_valid_ff && !in_ends, !req_stall)
   // a result appears only from a closing item or a held result
   `SDTI_ASSERT_NXT(a_no_spurious, !rsp_keep, !rsp_valid_ff)

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for strict_decimal_text_to_int: directed strings, then random ones
// depends on sdti_pkg and the rtl of strict_decimal_text_to_int
`timescale 1ns / 1ps

module tb_top;
   import sdti_pkg::*;

   localparam int CHAR_TARGET    = 1600;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int N_SCRIPT       = 27;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PARSE_BLANKS,
      PARSE_SIGNED,
      PARSE_DIGITS,
      PARSE_BROKEN
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]                    ch;
      logic                          eos;
      logic                          typed;
      logic                          status;
      logic signed [RESULT_BITS-1:0] value;
   } script_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // parser copy kept by the bench
   parse_phase_type text_phase = PARSE_BLANKS;
   logic            text_negative = 1'b0;
   longint unsigned text_magnitude = 0;
   logic            text_overflowed = 1'b0;

   rsp_item_type expected_numbers[$];

   int n_chars      = 0;
   int n_strings    = 0;
   int n_accepted   = 0;
   int n_rejected   = 0;
   int n_out_range  = 0;
   int n_mismatches = 0;
   int quiet_cycles = 0;

   int          send_mode  = 1;
   int          drain_mode = 1;
   int unsigned stall_left = 0;
   int unsigned rx_roll;

   // directed strings, one character per row
   script_row_type script_rows [N_SCRIPT] = '{
      // empty string closed by the marker
      '{CH_NUL,   1'b1, 1'b1, STATUS_ERROR, 32'sd0},
      // empty string closed by a zero byte
      '{CH_NUL,   1'b0, 1'b1, STATUS_ERROR, 32'sd0},
      // whitespace only; the character beside the marker is ignored
      '{CH_TAB,   1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_VT,    1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{"7",      1'b1, 1'b1, STATUS_ERROR, 32'sd0},
      // sign without digits
      '{CH_MINUS, 1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_SPACE, 1'b1, 1'b1, STATUS_ERROR, 32'sd0},
      // two signs
      '{CH_MINUS, 1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_PLUS,  1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_NUL,   1'b1, 1'b1, STATUS_ERROR, 32'sd0},
      // sign after a digit
      '{"7",      1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_MINUS, 1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_NUL,   1'b1, 1'b1, STATUS_ERROR, 32'sd0},
      // blank, plus, leading zero, closed by a zero byte
      '{CH_CR,    1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_PLUS,  1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{"0",      1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{"9",      1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_NUL,   1'b0, 1'b1, STATUS_OK,    32'sd9},
      // stray top byte, then characters after the format error
      '{8'hFF,    1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{"5",      1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_NUL,   1'b1, 1'b1, STATUS_ERROR, 32'sd0},
      // whitespace after the digits
      '{"5",      1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_SPACE, 1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{CH_NUL,   1'b1, 1'b1, STATUS_ERROR, 32'sd0},
      // negative zero, marker with a top byte beside it
      '{CH_MINUS, 1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{"0",      1'b0, 1'b0, STATUS_OK,    32'sd0},
      '{8'hFF,    1'b1, 1'b1, STATUS_OK,    32'sd0}
   };

   strict_decimal_text_to_int dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next parser state for one character; returns 1 with the number when the string closes
   function automatic logic parse_char(input req_item_type it, output rsp_item_type number);
      longint unsigned ceiling;
      longint unsigned digit;
      logic [63:0]     wide;
      number = '0;
      if (it.end_of_string || it.character == CH_NUL) begin
         if (text_phase == PARSE_DIGITS && !text_overflowed) begin
            wide = text_negative ? 64'd0 - text_magnitude : text_magnitude;
            number.status = STATUS_OK;
            number.value  = wide[RESULT_BITS-1:0];
         end else begin
            number.status = STATUS_ERROR;
            number.value  = '0;
            if (text_overflowed) n_out_range++;
         end
         text_phase      = PARSE_BLANKS;
         text_negative   = 1'b0;
         text_magnitude  = 0;
         text_overflowed = 1'b0;
         return 1'b1;
      end
      if (text_phase == PARSE_BROKEN) begin
         // swallow everything up to the end of the string
      end else if (text_phase == PARSE_BLANKS &&
                   it.character inside {CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE}) begin
         // leading blanks
      end else if (text_phase == PARSE_BLANKS &&
                   (it.character == CH_PLUS || it.character == CH_MINUS)) begin
         text_negative = (it.character == CH_MINUS);
         text_phase    = PARSE_SIGNED;
      end else if (it.character >= CH_ZERO && it.character <= CH_NINE) begin
         // range check before the multiply by ten; the mark is sticky
         ceiling = (64'd1 << (RESULT_BITS - 1)) - (text_negative ? 64'd0 : 64'd1);
         digit   = it.character - CH_ZERO;
         if (!text_overflowed) begin
            if (digit > ceiling || text_magnitude > (ceiling - digit) / 10)
               text_overflowed = 1'b1;
            else
               text_magnitude = text_magnitude * 10 + digit;
         end
         text_phase = PARSE_DIGITS;
      end else begin
         text_phase = PARSE_BROKEN;
      end
      return 1'b0;
   endfunction

   // drive one character, wait for acceptance and record the number it closes
   task automatic send_char(input req_item_type it, input logic typed,
                            input rsp_item_type typed_number);
      int           gap;
      int unsigned  roll;
      rsp_item_type number;
      roll = $urandom_range(0, 99);
      gap  = 0;
      if (send_mode == 1) begin
         if (roll < 3) gap = $urandom_range(8, 30);
         else if (roll < 20) gap = $urandom_range(1, 3);
      end else if (send_mode == 2) begin
         if (roll < 10) gap = $urandom_range(10, 40);
         else if (roll < 60) gap = $urandom_range(1, 4);
      end
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      n_chars++;
      if (parse_char(it, number)) begin
         n_strings++;
         expected_numbers.push_back(typed ? typed_number : number);
      end
   endtask

   // stop sending until every expected number has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver stalls: modes of none, light and heavy, with rare long holds
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rx_roll = $urandom_range(0, 99);
         if (drain_mode == 0 || rx_roll >= (drain_mode == 1 ? 15 : 50)) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= (rx_roll < 3) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         end
      end
      if ($urandom_range(0, 299) == 0) drain_mode <= $urandom_range(0, 2);
   end

   // compare each returned number with the oldest one expected
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_numbers.size() == 0) begin
            n_mismatches++;
            $display("%0t: unexpected result, got status %0d value %0d",
                     $time, rsp_item.status, rsp_item.value);
         end else begin
            if (rsp_item.status == STATUS_OK) n_accepted++;
            else n_rejected++;
            if (rsp_item.status !== expected_numbers[0].status) begin
               n_mismatches++;
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, expected_numbers[0].status, rsp_item.status);
            end
            if (rsp_item.value !== expected_numbers[0].value) begin
               n_mismatches++;
               $display("%0t: value mismatch, expected %0d, got %0d",
                        $time, expected_numbers[0].value, rsp_item.value);
            end
            void'(expected_numbers.pop_front());
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [7:0]      text[$];
      int unsigned     kind;
      int unsigned     form;
      int unsigned     len;
      int unsigned     pos;
      longint unsigned num;
      string           digits;
      logic [7:0]      blanks [6];
      rsp_item_type    none;

      blanks = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE};
      none   = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed strings
      for (int i = 0; i < N_SCRIPT; i++)
         send_char('{character: script_rows[i].ch, end_of_string: script_rows[i].eos},
                   script_rows[i].typed,
                   '{status: script_rows[i].status, value: script_rows[i].value});
      wait_drained();

      // random strings, mostly well formed
      while (n_chars < CHAR_TARGET + N_SCRIPT) begin
         text.delete();
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            repeat ($urandom_range(0, 3)) text.push_back(blanks[$urandom_range(0, 5)]);
            case ($urandom_range(0, 2))
               1: text.push_back(CH_PLUS);
               2: text.push_back(CH_MINUS);
               default: ;
            endcase
            form = $urandom_range(0, 9);
            if (kind >= 60 && $urandom_range(0, 3) == 0) begin
               // sign or blanks with no digits at all
            end else if (form < 6) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 13) : $urandom_range(1, 5);
               repeat (len) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else begin
               // values around the range limits, some with leading zeros
               if (form < 9) num = 64'd2147483645 + $urandom_range(0, 6);
               else num = $urandom();
               repeat ($urandom_range(0, 2)) text.push_back(CH_ZERO);
               digits = $sformatf("%0d", num);
               for (int i = 0; i < digits.len(); i++) text.push_back(digits[i]);
            end
            // broken strings: stray byte, extra sign or trailing blank
            if (kind >= 60) begin
               pos = $urandom_range(0, text.size());
               case ($urandom_range(0, 2))
                  0: text.insert(pos, 8'($urandom_range(1, 255)));
                  1: text.insert(pos, ($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
                  default: text.push_back(blanks[$urandom_range(0, 5)]);
               endcase
            end
         end else if (kind < 90) begin
            repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(8'h08, 8'h3A)));
         end

         if ($urandom_range(0, 19) == 0) send_mode = $urandom_range(0, 2);
         foreach (text[i])
            send_char('{character: text[i], end_of_string: 1'b0}, 1'b0, none);
         if ($urandom_range(0, 9) < 7)
            send_char('{character: 8'($urandom_range(0, 255)), end_of_string: 1'b1},
                      1'b0, none);
         else
            send_char('{character: CH_NUL, end_of_string: 1'b0}, 1'b0, none);

         if (n_strings % 60 == 59) wait_drained();
      end

      wait_drained();
      $display("sent %0d characters in %0d strings, results seen: %0d numbers, %0d rejected",
               n_chars, n_strings, n_accepted, n_rejected);
      $display("out-of-range strings: %0d, mismatches: %0d", n_out_range, n_mismatches);
      if (n_mismatches == 0 && expected_numbers.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
